// File: rtl/core/audio_command_list_translator_unit_assert.svh
// assertion macros shared by the checker
`ifndef AUDIO_COMMAND_LIST_TRANSLATOR_UNIT_ASSERT_SVH
`define AUDIO_COMMAND_LIST_TRANSLATOR_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define ACLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aclt check failed");

// next-cycle implication, masked during reset
`define ACLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aclt check failed");

// next-cycle implication, active through reset
`define ACLT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("aclt check failed");

`endif

// File: rtl/core/aclt_pkg.sv
package aclt_pkg;

    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_PASS = 2'd1;
    localparam logic [1:0] MODE_CAPT = 2'd2;
    localparam logic [1:0] MODE_SKIP = 2'd3;

    localparam logic [15:0] CMD_NOP2     = 16'h0000;
    localparam logic [15:0] CMD_SET_ADDR = 16'h0002;
    localparam logic [15:0] CMD_PUT_ADDR = 16'h0003;
    localparam logic [15:0] CMD_MIX_A    = 16'h0004;
    localparam logic [15:0] CMD_MIX_B    = 16'h0005;
    localparam logic [15:0] CMD_SKIP2_A  = 16'h0007;
    localparam logic [15:0] CMD_MIX_C    = 16'h000E;
    localparam logic [15:0] CMD_END      = 16'h000F;
    localparam logic [15:0] CMD_SKIP4    = 16'h0010;
    localparam logic [15:0] CMD_SKIP2_B  = 16'h0011;
    localparam logic [15:0] CMD_MIX_D    = 16'h0012;
    localparam logic [15:0] CMD_SKIP12   = 16'h0013;

    localparam logic [15:0] OUT_NOP2     = 16'h0000;
    localparam logic [15:0] OUT_PUT_ADDR = 16'h0004;
    localparam logic [15:0] OUT_MIX_A    = 16'h0005;
    localparam logic [15:0] OUT_MIX_B    = 16'h0006;
    localparam logic [15:0] OUT_MIX_C    = 16'h000B;
    localparam logic [15:0] OUT_MIX_D    = 16'h000A;
    localparam logic [15:0] OUT_TERM     = 16'h000E;
    localparam logic [15:0] OUT_FLAG     = 16'h8000;

    localparam logic REG_LIST_LENGTH  = 1'b0;
    localparam logic REG_OUT_CAPACITY = 1'b1;

    localparam logic [15:0] LIST_LENGTH_RST  = 16'd1;
    localparam logic [15:0] OUT_CAPACITY_RST = 16'hFFFF;

    typedef struct packed {
        logic [3:0][15:0] words;
        logic [2:0]       cnt;
        logic             term;
    } t_grp;

endpackage

// File: rtl/core/aclt_front.sv
module aclt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [15:0]       i_word,
    input  logic [15:0]       i_list_length,
    output logic              o_grp_valid,
    output aclt_pkg::t_grp    o_grp
);
    import aclt_pkg::*;

    logic [15:0] r_pos, n_pos;
    logic [3:0]  r_ar, n_ar;
    logic [1:0]  r_mode, n_mode;
    logic [31:0] r_addr, n_addr;
    logic        r_fin, n_fin;

    logic [15:0] len;
    logic [16:0] nxt;
    logic        fit2, fit4, fit12, is_end;
    logic [1:0]  nb;
    t_grp        grp;

    always_comb begin
        n_pos  = r_pos;
        n_ar   = r_ar;
        n_mode = r_mode;
        n_addr = r_addr;
        n_fin  = r_fin;
        grp    = '0;
        nb     = 2'd0;
        len    = (i_list_length == 16'd0) ? 16'd1 : i_list_length;
        nxt    = {1'b0, r_pos} + 17'd1;
        fit2   = (nxt + 17'd2)  <= {1'b0, len};
        fit4   = (nxt + 17'd4)  <= {1'b0, len};
        fit12  = (nxt + 17'd12) <= {1'b0, len};
        is_end = nxt >= {1'b0, len};
        if (r_fin) begin
            n_fin = 1'b1;
        end else if (r_mode == MODE_CMD) begin
            unique case (i_word) inside
                CMD_NOP2: begin
                    if (fit2) begin
                        grp.words[0] = OUT_NOP2;
                        nb           = 2'd1;
                        n_mode       = MODE_PASS;
                        n_ar         = 4'd2;
                    end
                end
                CMD_SET_ADDR: begin
                    if (fit2) begin
                        n_mode = MODE_CAPT;
                        n_ar   = 4'd2;
                    end
                end
                CMD_PUT_ADDR: begin
                    grp.words[0] = OUT_PUT_ADDR;
                    grp.words[1] = r_addr[31:16];
                    grp.words[2] = r_addr[15:0];
                    nb           = 2'd3;
                end
                CMD_MIX_A, CMD_MIX_B, CMD_MIX_C: begin
                    if (fit4) begin
                        grp.words[0] = (i_word == CMD_MIX_A) ? OUT_MIX_A :
                                       (i_word == CMD_MIX_B) ? OUT_MIX_B : OUT_MIX_C;
                        grp.words[1] = OUT_FLAG;
                        nb           = 2'd2;
                        n_mode       = MODE_PASS;
                        n_ar         = 4'd4;
                    end
                end
                CMD_MIX_D: begin
                    if (fit4) begin
                        grp.words[0] = OUT_MIX_D;
                        nb           = 2'd1;
                        n_mode       = MODE_PASS;
                        n_ar         = 4'd4;
                    end
                end
                CMD_END: begin
                    grp.words[0] = OUT_TERM;
                    nb           = 2'd1;
                    n_fin        = 1'b1;
                end
                CMD_SKIP2_A, CMD_SKIP2_B: begin
                    if (fit2) begin
                        n_mode = MODE_SKIP;
                        n_ar   = 4'd2;
                    end
                end
                CMD_SKIP4: begin
                    if (fit4) begin
                        n_mode = MODE_SKIP;
                        n_ar   = 4'd4;
                    end
                end
                CMD_SKIP12: begin
                    if (fit12) begin
                        n_mode = MODE_SKIP;
                        n_ar   = 4'd12;
                    end
                end
                default: begin
                    n_fin = 1'b1;
                end
            endcase
        end else begin
            if (r_mode == MODE_PASS) begin
                grp.words[0] = i_word;
                nb           = 2'd1;
            end else if (r_mode == MODE_CAPT) begin
                n_addr = {r_addr[15:0], i_word};
            end
            if (r_ar != 4'd0) begin
                n_ar = r_ar - 4'd1;
            end
            if (n_ar == 4'd0) begin
                n_mode = MODE_CMD;
            end
        end
        if (is_end) begin
            grp.words[nb] = OUT_TERM;
            grp.term      = 1'b1;
            n_pos         = 16'd0;
            n_ar          = 4'd0;
            n_mode        = MODE_CMD;
            n_addr        = 32'd0;
            n_fin         = 1'b0;
        end else begin
            n_pos = nxt[15:0];
        end
        grp.cnt = {1'b0, nb} + {2'b00, is_end};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 16'd0;
            r_ar   <= 4'd0;
            r_mode <= MODE_CMD;
            r_addr <= 32'd0;
            r_fin  <= 1'b0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_ar   <= n_ar;
            r_mode <= n_mode;
            r_addr <= n_addr;
            r_fin  <= n_fin;
        end
    end

    assign o_grp_valid = i_accept && (grp.cnt != 3'd0);
    assign o_grp       = grp;

endmodule

// File: rtl/core/aclt_queue.sv
module aclt_queue #(
    parameter int QDEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  aclt_pkg::t_grp    i_grp,
    input  logic              i_rd,
    output logic              o_full,
    output logic              o_valid,
    output aclt_pkg::t_grp    o_head
);
    import aclt_pkg::*;

    localparam int AW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_grp          r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr) begin
                r_wp <= (r_wp == AW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= (r_rp == AW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_grp;
        end
    end

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

endmodule

// File: rtl/core/aclt_back.sv
module aclt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  aclt_pkg::t_grp    i_head,
    input  logic [15:0]       i_out_capacity,
    input  logic              i_pop,
    output logic              o_rd,
    output logic              o_empty,
    output logic [15:0]       o_out_word,
    output logic              o_kept,
    output logic              o_last,
    output logic [15:0]       o_out_count
);
    import aclt_pkg::*;

    logic [1:0]  r_idx;
    logic [15:0] r_stored;
    logic        r_valid;
    logic [15:0] r_word, r_count;
    logic        r_kept, r_last;

    logic        load, tail, kept, is_last;
    logic [15:0] cnt_new;

    always_comb begin
        load    = i_valid && (!r_valid || i_pop);
        tail    = ({1'b0, r_idx} + 3'd1) == i_head.cnt;
        is_last = i_head.term && tail;
        kept    = r_stored < i_out_capacity;
        cnt_new = kept ? r_stored + 16'd1 : r_stored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 2'd0;
            r_stored <= 16'd0;
            r_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_idx    <= tail ? 2'd0 : r_idx + 2'd1;
                r_stored <= is_last ? 16'd0 : cnt_new;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word  <= i_head.words[r_idx];
            r_kept  <= kept;
            r_last  <= is_last;
            r_count <= cnt_new;
        end
    end

    assign o_rd        = load && tail;
    assign o_empty     = !r_valid;
    assign o_out_word  = r_word;
    assign o_kept      = r_kept;
    assign o_last      = r_last;
    assign o_out_count = r_count;

endmodule

// File: rtl/core/audio_command_list_translator_unit.sv
// Command list translator. Source words enter through push/full, one word per
// cycle while the group queue between the parser and the emitter has room; each
// word is parsed at once and yields zero to four result beats, which leave
// through empty/pop at one beat per cycle from the output register. Sustained
// throughput is therefore set by the result port. QDEPTH sets how many
// groups of beats may wait between the parser and the emitter. The list length
// and output capacity are written over the APB port at offsets 0x0 and 0x4.
module audio_command_list_translator_unit #(
    parameter int QDEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_word,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_out_word,
    output logic        o_kept,
    output logic        o_last,
    output logic [15:0] o_out_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aclt_pkg::*;

    logic [15:0] r_list_length, r_out_capacity;
    logic        cfg_wr, accept, grp_valid, q_valid, q_full, q_rd;
    t_grp        grp, head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_length  <= LIST_LENGTH_RST;
            r_out_capacity <= OUT_CAPACITY_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_LIST_LENGTH:  r_list_length  <= pwdata[15:0];
                REG_OUT_CAPACITY: r_out_capacity <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LIST_LENGTH:  prdata = {16'd0, r_list_length};
            REG_OUT_CAPACITY: prdata = {16'd0, r_out_capacity};
            default:          prdata = 32'd0;
        endcase
    end

    assign full   = q_full;
    assign accept = push && !full;

    aclt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_word        (i_word),
        .i_list_length (r_list_length),
        .o_grp_valid   (grp_valid),
        .o_grp         (grp)
    );

    aclt_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (grp_valid),
        .i_grp   (grp),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    aclt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_head         (head),
        .i_out_capacity (r_out_capacity),
        .i_pop          (pop),
        .o_rd           (q_rd),
        .o_empty        (empty),
        .o_out_word     (o_out_word),
        .o_kept         (o_kept),
        .o_last         (o_last),
        .o_out_count    (o_out_count)
    );

endmodule

// File: rtl/core/aclt_checker.sv
`include "audio_command_list_translator_unit_assert.svh"

module aclt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] o_out_word,
    input  logic        o_kept,
    input  logic        o_last,
    input  logic [15:0] o_out_count
);

    `ACLT_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, empty)
    `ACLT_ASSERT_NOW(a_last_term, i_clk, i_rst_n, !empty && o_last, o_out_word == 16'h000E)
    `ACLT_ASSERT_NOW(a_kept_count, i_clk, i_rst_n, !empty && o_kept, o_out_count != 16'd0)
    `ACLT_ASSERT_NEXT(a_hold_beat, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out_word))

endmodule

bind audio_command_list_translator_unit aclt_checker u_aclt_checker (.*);

// File: tb/tb_audio_command_list_translator_unit.sv
`timescale 1ns / 100ps

module tb_audio_command_list_translator_unit;
    import aclt_pkg::*;

    localparam logic [2:0] ADDR_LEN = {REG_LIST_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_CAP = {REG_OUT_CAPACITY, 2'b00};
    localparam int N_ROWS = 35;
    localparam int N_WORDS = 130;

    typedef struct packed {
        logic [15:0] word;
        logic        kept;
        logic        last;
        logic [15:0] count;
    } t_beat;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  addr;
        logic [15:0] val;
        logic        typed;
        t_beat       want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] i_word = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_out_word;
    logic        o_kept;
    logic        o_last;
    logic [15:0] o_out_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    audio_command_list_translator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_word      (i_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word),
        .o_kept      (o_kept),
        .o_last      (o_last),
        .o_out_count (o_out_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // translator state as the block should hold it
    logic [15:0] len_reg;
    logic [15:0] cap_reg;
    logic [15:0] list_pos;
    logic [3:0]  args_left;
    logic [1:0]  arg_mode;
    logic [31:0] blk_addr;
    logic        list_done;
    logic [15:0] stored_cnt;

    t_beat    step_beats[$];
    t_beat    pending_beats[$];
    t_dir_row dir_rows [N_ROWS];
    logic [15:0] cmd_pool [12];

    int mismatches = 0;
    int words_fed = 0;
    int gen_left = 0;
    bit quiet = 1'b0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int idle_left = 0;

    function automatic void clear_list();
        list_pos = '0;
        args_left = '0;
        arg_mode = MODE_CMD;
        blk_addr = '0;
        list_done = 1'b0;
        stored_cnt = '0;
    endfunction

    function automatic void add_beat(input logic [15:0] v, input logic lst);
        logic kept;
        kept = stored_cnt < cap_reg;
        if (kept)
            stored_cnt = stored_cnt + 16'd1;
        if (step_beats.size() < 4)
            step_beats.push_back('{v, kept, lst, stored_cnt});
    endfunction

    function automatic void translate_word(input logic [15:0] w);
        int len;
        int nxt;
        len = (len_reg == 0) ? 1 : int'(len_reg);
        nxt = int'(list_pos) + 1;
        step_beats.delete();
        if (list_done) begin
        end else if (arg_mode == MODE_CMD) begin
            case (w)
                CMD_NOP2: begin
                    if (nxt + 2 <= len) begin
                        add_beat(OUT_NOP2, 1'b0);
                        arg_mode = MODE_PASS;
                        args_left = 4'd2;
                    end
                end
                CMD_SET_ADDR: begin
                    if (nxt + 2 <= len) begin
                        arg_mode = MODE_CAPT;
                        args_left = 4'd2;
                    end
                end
                CMD_PUT_ADDR: begin
                    add_beat(OUT_PUT_ADDR, 1'b0);
                    add_beat(blk_addr[31:16], 1'b0);
                    add_beat(blk_addr[15:0], 1'b0);
                end
                CMD_MIX_A, CMD_MIX_B, CMD_MIX_C: begin
                    if (nxt + 4 <= len) begin
                        add_beat((w == CMD_MIX_A) ? OUT_MIX_A :
                                 (w == CMD_MIX_B) ? OUT_MIX_B : OUT_MIX_C, 1'b0);
                        add_beat(OUT_FLAG, 1'b0);
                        arg_mode = MODE_PASS;
                        args_left = 4'd4;
                    end
                end
                CMD_MIX_D: begin
                    if (nxt + 4 <= len) begin
                        add_beat(OUT_MIX_D, 1'b0);
                        arg_mode = MODE_PASS;
                        args_left = 4'd4;
                    end
                end
                CMD_END: begin
                    add_beat(OUT_TERM, 1'b0);
                    list_done = 1'b1;
                end
                CMD_SKIP2_A, CMD_SKIP2_B: begin
                    if (nxt + 2 <= len) begin
                        arg_mode = MODE_SKIP;
                        args_left = 4'd2;
                    end
                end
                CMD_SKIP4: begin
                    if (nxt + 4 <= len) begin
                        arg_mode = MODE_SKIP;
                        args_left = 4'd4;
                    end
                end
                CMD_SKIP12: begin
                    if (nxt + 12 <= len) begin
                        arg_mode = MODE_SKIP;
                        args_left = 4'd12;
                    end
                end
                default: list_done = 1'b1;
            endcase
        end else begin
            if (arg_mode == MODE_PASS)
                add_beat(w, 1'b0);
            else if (arg_mode == MODE_CAPT)
                blk_addr = {blk_addr[15:0], w};
            if (args_left != 0)
                args_left = args_left - 4'd1;
            if (args_left == 0)
                arg_mode = MODE_CMD;
        end
        if (nxt >= len) begin
            add_beat(OUT_TERM, 1'b1);
            clear_list();
        end else begin
            list_pos = nxt[15:0];
        end
    endfunction

    // mostly well-formed commands with random arguments, some noise
    function automatic logic [15:0] gen_word(input int room);
        logic [15:0] cmd;
        int argc;
        argc = 0;
        if (gen_left > 0) begin
            gen_left--;
            return 16'($urandom);
        end
        if ($urandom_range(0, 11) == 0)
            return 16'($urandom);
        cmd = cmd_pool[0];
        for (int t = 0; t < 4; t++) begin
            cmd = cmd_pool[$urandom_range(0, 11)];
            case (cmd)
                CMD_NOP2, CMD_SET_ADDR, CMD_SKIP2_A, CMD_SKIP2_B: argc = 2;
                CMD_MIX_A, CMD_MIX_B, CMD_MIX_C, CMD_MIX_D, CMD_SKIP4: argc = 4;
                CMD_SKIP12: argc = 12;
                default: argc = 0;
            endcase
            if (argc <= room)
                break;
        end
        gen_left = argc;
        return cmd;
    endfunction

    function automatic t_dir_row row_word(input logic [15:0] w);
        return '{1'b0, 3'd0, w, 1'b0, t_beat'('0)};
    endfunction

    function automatic t_dir_row row_typed(input logic [15:0] w, input t_beat b);
        return '{1'b0, 3'd0, w, 1'b1, b};
    endfunction

    function automatic t_dir_row row_cfg(input logic [2:0] a, input logic [15:0] v);
        return '{1'b1, a, v, 1'b0, t_beat'('0)};
    endfunction

    task automatic send_word(input logic [15:0] w, input logic typed, input t_beat want);
        if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_word <= w;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        translate_word(w);
        if (typed)
            pending_beats.push_back(want);
        else
            foreach (step_beats[k])
                pending_beats.push_back(step_beats[k]);
        words_fed++;
    endtask

    // drain every beat, then allow the pipeline to settle
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[2] == REG_LIST_LENGTH)
            len_reg = val;
        else
            cap_reg = val;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = '{o_out_word, o_kept, o_last, o_out_count};
                if (pending_beats.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat word=%h kept=%b last=%b count=%0d",
                             $time, got.word, got.kept, got.last, got.count);
                end else begin
                    want = pending_beats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: expected word=%h kept=%b last=%b count=%0d, got word=%h kept=%b last=%b count=%0d",
                                 $time, want.word, want.kept, want.last, want.count,
                                 got.word, got.kept, got.last, got.count);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                idle_left = $urandom_range(0, 15);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int len;
        int eff;
        int cut;
        int fed;
        bit held;
        bit lower;
        cmd_pool = '{CMD_NOP2, CMD_SET_ADDR, CMD_PUT_ADDR, CMD_MIX_A, CMD_MIX_B, CMD_SKIP2_A,
                     CMD_MIX_C, CMD_END, CMD_SKIP4, CMD_SKIP2_B, CMD_MIX_D, CMD_SKIP12};
        dir_rows = '{
            row_typed(CMD_NOP2, '{OUT_TERM, 1'b1, 1'b1, 16'd1}),
            row_cfg(ADDR_LEN, 16'd0),
            row_typed(16'hFFFF, '{OUT_TERM, 1'b1, 1'b1, 16'd1}),
            row_cfg(ADDR_LEN, 16'd9),
            row_word(CMD_SET_ADDR), row_word(16'h1234), row_word(16'h5678),
            row_word(CMD_PUT_ADDR),
            row_word(CMD_MIX_D), row_word(16'hFFFF), row_word(16'h0000),
            row_word(16'h8000), row_word(16'h7FFF),
            row_cfg(ADDR_CAP, 16'd0),
            row_cfg(ADDR_LEN, 16'd3),
            row_word(CMD_MIX_A),
            row_typed(CMD_END, '{OUT_TERM, 1'b0, 1'b0, 16'd0}),
            row_typed(CMD_SKIP12, '{OUT_TERM, 1'b0, 1'b1, 16'd0}),
            row_cfg(ADDR_CAP, 16'd2),
            row_cfg(ADDR_LEN, 16'hFFFF),
            row_word(CMD_MIX_B), row_word(16'h0001), row_word(16'h0002),
            row_word(16'h0003), row_word(16'h0004),
            row_word(CMD_MIX_C), row_word(16'h00AA), row_word(16'h00BB),
            row_cfg(ADDR_LEN, 16'd4),
            row_word(16'h00CC),
            row_cfg(ADDR_CAP, 16'hFFFF),
            row_cfg(ADDR_LEN, 16'd3),
            row_word(CMD_SKIP2_B), row_word(16'hAAAA), row_word(16'h5555)
        };
        len_reg = LIST_LENGTH_RST;
        cap_reg = OUT_CAPACITY_RST;
        clear_list();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                wait_idle();
                write_reg(dir_rows[r].addr, dir_rows[r].val);
            end else begin
                send_word(dir_rows[r].val, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        words_fed = 0;
        held = 1'b0;
        while (words_fed < N_WORDS) begin
            wait_idle();
            case ($urandom_range(0, 19))
                0: len = 0;
                1: len = 1;
                2: len = 65535;
                default: len = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 9))
                0: write_reg(ADDR_CAP, 16'd0);
                1, 2: write_reg(ADDR_CAP, 16'($urandom_range(1, 12)));
                3: write_reg(ADDR_CAP, 16'($urandom_range(13, 65535)));
                default: write_reg(ADDR_CAP, 16'hFFFF);
            endcase
            write_reg(ADDR_LEN, 16'(len));
            eff = (len == 0) ? 1 : len;
            lower = (len == 65535) || (eff > 3 && $urandom_range(0, 9) == 0);
            cut = lower ? $urandom_range(1, (eff - 1 < 30) ? eff - 1 : 30) : 0;
            quiet = words_fed >= N_WORDS - 40;
            calm = $urandom_range(0, 3) == 0;
            gen_left = 0;
            if (!held && eff >= 16) begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            fed = 0;
            do begin
                if (lower && fed == cut) begin
                    wait_idle();
                    write_reg(ADDR_LEN, 16'($urandom_range(1, cut + 6)));
                end
                send_word(gen_word(((len_reg == 0) ? 1 : int'(len_reg)) - int'(list_pos) - 1),
                          1'b0, t_beat'('0));
                fed++;
            end while (list_pos != 0);
        end

        push <= 1'b0;
        for (int c = 0; c < 50000 && pending_beats.size() != 0; c++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_beats.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected beats never arrived", $time, pending_beats.size());
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
